/* rtl/hidx_pkg.sv */
// Shared types and constants of the h-index histogram core.
package hidx_pkg;

  // Fixed width of the reported h-index field.
  localparam int unsigned H_VALUE_W = 11;

  // Output word: h_value and overflow packed, padded to whole bytes.
  localparam int unsigned OUT_TDATA_W = ((H_VALUE_W + 1 + 7) / 8) * 8;

  // One finished result as it travels from the back end to the output port.
  typedef struct packed {
    logic                 overflow;
    logic [H_VALUE_W-1:0] h_value;
  } hidx_result_t;

  // Back end sequencer states.
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_SETTLE = 5'b00100,
    ST_WALK   = 5'b01000,
    ST_FINISH = 5'b10000
  } hidx_state_e;

endpackage

/* rtl/hidx_front.sv */
// Input side of the h-index core: accepts citation words and clamps them to bin indexes.
module hidx_front #(
  parameter int unsigned MAX_PAPERS    = 1024,
  parameter int unsigned CITATION_BITS = 16,
  parameter int unsigned AW            = 11,
  parameter int unsigned TDATA_W       = 16
) (
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [TDATA_W-1:0] s_tdata_i,
  input  logic               s_tlast_i,
  output logic               q_push_o,
  output logic [AW:0]        q_entry_o,
  input  logic               q_full_i
);

  // Compare width wide enough for both the citation count and the bin limit.
  localparam int unsigned CMP_W = ((CITATION_BITS > AW) ? CITATION_BITS : AW) + 1;

  logic [CITATION_BITS-1:0] cit;
  logic [CMP_W-1:0]         cit_ext;
  logic [AW-1:0]            bin;

  // Clamp the count to the top bin.
  always_comb begin
    cit     = s_tdata_i[CITATION_BITS-1:0];
    cit_ext = CMP_W'(cit);
    if (cit_ext >= CMP_W'(MAX_PAPERS)) begin
      bin = AW'(MAX_PAPERS);
    end else begin
      bin = AW'(cit_ext);
    end
  end

  // A word is taken whenever the queue has room.
  assign s_tready_o = ~q_full_i;
  assign q_push_o   = s_tvalid_i & ~q_full_i;
  assign q_entry_o  = {s_tlast_i, bin};

endmodule

/* rtl/hidx_fifo.sv */
// Short queue of binned words between the front and back ends.
module hidx_fifo #(
  parameter int unsigned W     = 12,
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o     = (count_q == CW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;

  // Pointer and fill level update with explicit wrap.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/hidx_back.sv */
// Back end of the h-index core: histogram memory, bin updates and the final walk.
module hidx_back #(
  parameter int unsigned MAX_PAPERS = 1024,
  parameter int unsigned AW         = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  logic [AW:0]           q_entry_i,
  output logic                  q_pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output hidx_pkg::hidx_result_t res_o
);
  import hidx_pkg::*;

  localparam int unsigned DEPTH = MAX_PAPERS + 1;

  // Histogram storage.
  logic [AW-1:0] hist_mem [DEPTH];
  logic [AW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, mem_wdata;

  hidx_state_e   state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;

  // Update stage: bin of the word popped last cycle.
  logic          b_valid_q;
  logic [AW-1:0] b_bin_q;
  // Write of the previous cycle, for forwarding.
  logic          w_valid_q;
  logic [AW-1:0] w_addr_q, w_val_q;
  logic [AW-1:0] cur_count, inc_count;

  // Walk check stage.
  logic          chk_valid_q, chk_valid_d;
  logic [AW-1:0] chk_idx_q;
  logic [AW-1:0] sum_q, sum_d;
  logic [AW:0]   sum_ext;
  logic          found_q, found_d;
  logic [AW-1:0] h_q, h_d;

  logic [AW-1:0] total_q, total_d;
  logic          ovf_q, ovf_d;

  logic          res_valid_q, res_valid_d;
  hidx_result_t  res_q, res_d;

  logic          pop;
  logic [AW-1:0] pop_bin;
  logic          pop_last;

  assign pop_bin  = q_entry_i[AW-1:0];
  assign pop_last = q_entry_i[AW];
  assign pop      = (state_q == ST_LOAD) && q_valid_i;
  assign q_pop_o  = pop;

  // Saturating increment with forwarding of the previous cycle's write to the same bin.
  always_comb begin
    cur_count = (w_valid_q && (w_addr_q == b_bin_q)) ? w_val_q : rdata_q;
    inc_count = (cur_count < AW'(MAX_PAPERS)) ? cur_count + AW'(1) : cur_count;
  end

  // Memory port selection: sweeps write zeros, loading writes increments.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;
    mem_raddr = (state_q == ST_WALK) ? idx_q : pop_bin;
    if ((state_q == ST_CLEAR) || (state_q == ST_WALK)) begin
      mem_we = 1'b1;
    end else if (b_valid_q) begin
      mem_we    = 1'b1;
      mem_waddr = b_bin_q;
      mem_wdata = inc_count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= hist_mem[mem_raddr];
  end

  // Running sum over the walk, saturated at the top bin index.
  always_comb begin
    sum_ext = {1'b0, sum_q} + {1'b0, rdata_q};
    sum_d   = sum_q;
    found_d = found_q;
    h_d     = h_q;
    if (chk_valid_q) begin
      sum_d = (sum_ext > (AW + 1)'(MAX_PAPERS)) ? AW'(MAX_PAPERS) : sum_ext[AW-1:0];
      if (!found_q && ((sum_d >= chk_idx_q) || (chk_idx_q == '0))) begin
        found_d = 1'b1;
        h_d     = chk_idx_q;
      end
    end
  end

  // Sequencer and set bookkeeping.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    chk_valid_d = 1'b0;
    total_d     = total_q;
    ovf_d       = ovf_q;
    res_valid_d = res_valid_q & ~res_ready_i;
    res_d       = res_q;

    if (b_valid_q) begin
      if (total_q < AW'(MAX_PAPERS)) begin
        total_d = total_q + AW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        idx_d = idx_q - AW'(1);
        if (idx_q == '0) begin
          idx_d   = AW'(MAX_PAPERS);
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (pop && pop_last) begin
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        chk_valid_d = 1'b1;
        idx_d       = idx_q - AW'(1);
        if (idx_q == '0) begin
          idx_d   = AW'(MAX_PAPERS);
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!chk_valid_q && (!res_valid_q || res_ready_i)) begin
          res_valid_d   = 1'b1;
          res_d.h_value = H_VALUE_W'(h_q);
          res_d.overflow = ovf_q;
          total_d       = '0;
          ovf_d         = 1'b0;
          state_d       = ST_LOAD;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= AW'(MAX_PAPERS);
      b_valid_q   <= 1'b0;
      w_valid_q   <= 1'b0;
      chk_valid_q <= 1'b0;
      found_q     <= 1'b0;
      sum_q       <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      b_valid_q   <= pop;
      w_valid_q   <= b_valid_q;
      chk_valid_q <= chk_valid_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      res_valid_q <= res_valid_d;
      // A new walk starts from an empty sum.
      if (state_q == ST_SETTLE) begin
        sum_q   <= '0;
        found_q <= 1'b0;
      end else begin
        sum_q   <= sum_d;
        found_q <= found_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    b_bin_q   <= pop_bin;
    w_addr_q  <= b_bin_q;
    w_val_q   <= inc_count;
    chk_idx_q <= idx_q;
    h_q       <= h_d;
    res_q     <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Bin updates only happen while a set is loading or just finished loading.
  a_update_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> ((state_q == ST_LOAD) || (state_q == ST_SETTLE)))
    else $error("bin update outside of loading");

  // The running sum never passes the top bin index.
  a_sum_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= AW'(MAX_PAPERS))
    else $error("running sum beyond limit");

  // Once found during a walk, the h-index is not lost.
  a_found_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && (state_q == ST_WALK)) |=> found_q)
    else $error("found flag dropped during walk");

  // The walk always ends with an h-index in hand.
  a_finish_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && !chk_valid_q) |-> found_q)
    else $error("walk ended without a result");

  // A result is only produced at the end of a walk.
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> ($past(state_q) == ST_FINISH))
    else $error("result produced outside of finish");

endmodule

/* rtl/h_index_histogram_core.sv */
// Top level of the h-index histogram core.
//
//  Channel   Dir  Word                                   Ends with
//  s_axis    in   tdata: citation_count; tlast: last     citation word of a set
//  m_axis    out  tdata: h_value, overflow               one result per set
//
// Citation words load into the histogram at one word per cycle while a set is
// loading, through a short queue; a word with tlast set starts a walk over all
// MAX_PAPERS + 1 bins of the histogram memory, one bin per cycle on its single
// read port, which also clears them. After reset a clearing pass over all bins
// runs before words load from the queue into the histogram.
// The result sits in an output register, so a stalled m_axis holds back only
// the next walk's end, and input keeps filling the queue meanwhile.
module h_index_histogram_core #(
  parameter int unsigned MAX_PAPERS    = 1024,
  parameter int unsigned CITATION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tdata: [CITATION_BITS-1:0] citation_count, zero padded to whole bytes
  input  logic [((CITATION_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  logic s_axis_tlast_i,
  // tdata: [10:0] h_value, [11] overflow, zero padded to whole bytes
  output logic [hidx_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i
);
  import hidx_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_PAPERS + 1);
  localparam int unsigned TDATA_W = ((CITATION_BITS + 7) / 8) * 8;
  localparam int unsigned QDEPTH  = 4;

  logic         push, full, qvalid, qpop;
  logic [AW:0]  push_entry, pop_entry;
  hidx_result_t res;

  hidx_front #(
    .MAX_PAPERS    (MAX_PAPERS),
    .CITATION_BITS (CITATION_BITS),
    .AW            (AW),
    .TDATA_W       (TDATA_W)
  ) u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tlast_i  (s_axis_tlast_i),
    .q_push_o   (push),
    .q_entry_o  (push_entry),
    .q_full_i   (full)
  );

  hidx_fifo #(
    .W     (AW + 1),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .pop_i       (qpop),
    .valid_o     (qvalid),
    .pop_data_o  (pop_entry)
  );

  hidx_back #(
    .MAX_PAPERS (MAX_PAPERS),
    .AW         (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qvalid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (qpop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Pack the result word, h_value in the low bits and overflow above it.
  assign m_axis_tdata_o = OUT_TDATA_W'({res.overflow, res.h_value});

endmodule
